[rtl/core/mi3_pkg.sv]
`default_nettype none
package mi3_pkg;

    localparam int ELEMENT_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int OUT_WIDTH         = 32;
    // One quotient bit beyond the output width; larger quotients are caught up front.
    localparam int QUOT_BITS         = OUT_WIDTH + 1;
    localparam int NUM_ELEM          = 9;

    // Each cofactor is a[P]*a[Q] - a[R]*a[S], row-major element and cofactor order.
    localparam int ADJ_IDX [0:NUM_ELEM-1][0:3] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

endpackage
`default_nettype wire

[rtl/core/mi3_if.sv]
`default_nettype none
interface mi3_in_if #(
    parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface mi3_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mi3_pkg::OUT_WIDTH-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
    logic                                singular;
    logic                                saturated;

    modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                    singular, saturated, input ready);
    modport sink   (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                    singular, saturated, output ready);
endinterface
`default_nettype wire

[rtl/core/matrix_inverse_3x3_top.sv]
// Channel  Dir  Payload                                  Beat
// i_in     in   a00..a22 signed, ELEMENT_WIDTH bits      valid & ready
// o_out    out  b00..b22 signed 32 bits, singular, sat   valid & ready
//
// One matrix enters per cycle while the output beat is not held.
// The divider is radix-2: one quotient bit per stage, nine lanes wide.
// Reset (synchronous, active low) clears the valid bits of every stage.
// All stages advance together; when the output beat is held, the whole pipe holds
// and input ready drops, so nothing is lost or repeated.
`default_nettype none
module matrix_inverse_3x3_top #(
    parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mi3_in_if.sink     i_in,
    mi3_out_if.source  o_out
);
    import mi3_pkg::*;

    localparam int EW = ELEMENT_WIDTH;
    localparam int PW = 2 * EW;
    localparam int AW = PW + 1;
    localparam int LW = EW + 1;
    localparam int DW = 3 * EW + 3;
    localparam int NW = AW + 2 * FRAC_BITS;
    localparam int QB = QUOT_BITS;
    localparam int RW = ((DW > NW) ? DW : NW) + 1;
    localparam int CW = (NW > DW + QB) ? NW : DW + QB;
    localparam logic [QB:0] POS_MAX = {{(QB + 2 - OUT_WIDTH){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [QB:0] NEG_MAX = POS_MAX + (QB+1)'(1);

    logic en;
    logic signed [EW-1:0] w_a [0:NUM_ELEM-1];

    assign w_a[0] = i_in.a00;
    assign w_a[1] = i_in.a01;
    assign w_a[2] = i_in.a02;
    assign w_a[3] = i_in.a10;
    assign w_a[4] = i_in.a11;
    assign w_a[5] = i_in.a12;
    assign w_a[6] = i_in.a20;
    assign w_a[7] = i_in.a21;
    assign w_a[8] = i_in.a22;

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // Products, cofactors, row-0 terms, determinant.
    logic                 r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [PW-1:0] r1_p   [0:2*NUM_ELEM-1];
    logic signed [EW-1:0] r1_a0  [0:2];
    logic signed [AW-1:0] r2_adj [0:NUM_ELEM-1];
    logic signed [EW-1:0] r2_a0  [0:2];
    logic signed [PW-1:0] r3_ph  [0:2];
    logic signed [PW+1:0] r3_pl  [0:2];
    logic signed [AW-1:0] r3_adj [0:NUM_ELEM-1];
    logic signed [DW-1:0] r4_det;
    logic signed [AW-1:0] r4_adj [0:NUM_ELEM-1];
    logic        [DW-1:0] r5_dmag;
    logic                 r5_sing;
    logic        [NW-1:0] r5_num [0:NUM_ELEM-1];
    logic                 r5_neg [0:NUM_ELEM-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_ELEM; k++) begin
                r1_p[2*k]   <= w_a[ADJ_IDX[k][0]] * w_a[ADJ_IDX[k][1]];
                r1_p[2*k+1] <= w_a[ADJ_IDX[k][2]] * w_a[ADJ_IDX[k][3]];
                r2_adj[k]   <= AW'(r1_p[2*k]) - AW'(r1_p[2*k+1]);
                r3_adj[k]   <= r2_adj[k];
                r4_adj[k]   <= r3_adj[k];
                r5_num[k]   <= NW'(r4_adj[k][AW-1] ? $unsigned(-r4_adj[k])
                                                   : $unsigned(r4_adj[k])) << (2 * FRAC_BITS);
                r5_neg[k]   <= r4_adj[k][AW-1] ^ r4_det[DW-1];
            end
            // Each row-0 term is split at bit LW of the cofactor to keep the multipliers narrow.
            for (int j = 0; j < 3; j++) begin
                r1_a0[j] <= w_a[j];
                r2_a0[j] <= r1_a0[j];
                r3_ph[j] <= r2_a0[j] * $signed(r2_adj[3*j][AW-1:LW]);
                r3_pl[j] <= r2_a0[j] * $signed({1'b0, r2_adj[3*j][LW-1:0]});
            end
            r4_det  <= (DW'(r3_ph[0]) <<< LW) + DW'(r3_pl[0])
                     + (DW'(r3_ph[1]) <<< LW) + DW'(r3_pl[1])
                     + (DW'(r3_ph[2]) <<< LW) + DW'(r3_pl[2]);
            r5_dmag <= r4_det[DW-1] ? $unsigned(-r4_det) : $unsigned(r4_det);
            r5_sing <= (r4_det == '0);
        end
    end

    // Divider: stage 0 holds the overflow check and the start remainder.
    logic          r_dv   [0:QB];
    logic [DW-1:0] r_dd   [0:QB];
    logic          r_dsg  [0:QB];
    logic [RW-1:0] r_rem  [0:QB][0:NUM_ELEM-1];
    logic [QB-1:0] r_q    [0:QB][0:NUM_ELEM-1];
    logic [QB-1:0] r_low  [0:QB][0:NUM_ELEM-1];
    logic          r_neg  [0:QB][0:NUM_ELEM-1];
    logic          r_ovf  [0:QB][0:NUM_ELEM-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0]  <= r5_dmag;
            r_dsg[0] <= r5_sing;
            for (int l = 0; l < NUM_ELEM; l++) begin
                r_ovf[0][l] <= CW'(r5_num[l]) >= (CW'(r5_dmag) << QB);
                r_rem[0][l] <= RW'(r5_num[l] >> QB);
                r_low[0][l] <= QB'(r5_num[l]);
                r_q[0][l]   <= '0;
                r_neg[0][l] <= r5_neg[l];
            end
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [RW-1:0] n_rem [0:NUM_ELEM-1];
        logic          n_ge  [0:NUM_ELEM-1];

        always_comb begin
            for (int l = 0; l < NUM_ELEM; l++) begin
                n_rem[l] = {r_rem[k][l][RW-2:0], r_low[k][l][QB-1]};
                n_ge[l]  = n_rem[l] >= RW'(r_dd[k]);
                if (n_ge[l]) begin
                    n_rem[l] = n_rem[l] - RW'(r_dd[k]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dd[k+1]  <= r_dd[k];
                r_dsg[k+1] <= r_dsg[k];
                for (int l = 0; l < NUM_ELEM; l++) begin
                    r_rem[k+1][l] <= n_rem[l];
                    r_q[k+1][l]   <= {r_q[k][l][QB-2:0], n_ge[l]};
                    r_low[k+1][l] <= {r_low[k][l][QB-2:0], 1'b0};
                    r_neg[k+1][l] <= r_neg[k][l];
                    r_ovf[k+1][l] <= r_ovf[k][l];
                end
            end
        end
    end

    // Round half away from zero on the magnitude, then sign and clip.
    logic          r7_v, r7_sing;
    logic [QB:0]   r7_q   [0:NUM_ELEM-1];
    logic          r7_neg [0:NUM_ELEM-1];
    logic          r7_ovf [0:NUM_ELEM-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sing <= r_dsg[QB];
            for (int l = 0; l < NUM_ELEM; l++) begin
                r7_q[l]   <= {1'b0, r_q[QB][l]} +
                             (QB+1)'({r_rem[QB][l][RW-2:0], 1'b0} >= RW'(r_dd[QB]));
                r7_neg[l] <= r_neg[QB][l];
                r7_ovf[l] <= r_ovf[QB][l];
            end
        end
    end

    logic signed [OUT_WIDTH-1:0] n_b   [0:NUM_ELEM-1];
    logic                        n_clip [0:NUM_ELEM-1];
    logic                        n_sat;
    logic                        r_ov, r_osing, r_osat;
    logic signed [OUT_WIDTH-1:0] r_ob  [0:NUM_ELEM-1];

    always_comb begin
        n_sat = 1'b0;
        for (int l = 0; l < NUM_ELEM; l++) begin
            if (r7_neg[l]) begin
                n_clip[l] = r7_ovf[l] || (r7_q[l] > NEG_MAX);
                n_b[l]    = n_clip[l] ? $signed(NEG_MAX[OUT_WIDTH-1:0])
                                      : $signed(OUT_WIDTH'(-r7_q[l]));
            end else begin
                n_clip[l] = r7_ovf[l] || (r7_q[l] > POS_MAX);
                n_b[l]    = n_clip[l] ? $signed(POS_MAX[OUT_WIDTH-1:0])
                                      : $signed(r7_q[l][OUT_WIDTH-1:0]);
            end
            if (r7_sing) begin
                n_clip[l] = 1'b0;
                n_b[l]    = '0;
            end
            n_sat = n_sat | n_clip[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_osing <= r7_sing;
            r_osat  <= n_sat;
            for (int l = 0; l < NUM_ELEM; l++) begin
                r_ob[l] <= n_b[l];
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.singular  = r_osing;
    assign o_out.saturated = r_osat;
    assign o_out.b00       = r_ob[0];
    assign o_out.b01       = r_ob[1];
    assign o_out.b02       = r_ob[2];
    assign o_out.b10       = r_ob[3];
    assign o_out.b11       = r_ob[4];
    assign o_out.b12       = r_ob[5];
    assign o_out.b20       = r_ob[6];
    assign o_out.b21       = r_ob[7];
    assign o_out.b22       = r_ob[8];

    // A singular result carries zeros and never reports clipping.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.singular) |->
            (!o_out.saturated && o_out.b00 == '0 && o_out.b11 == '0 && o_out.b22 == '0))
        else $error("singular result with nonzero payload");

    // A zero divisor in the divider must be flagged singular.
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[0] && r_dd[0] == '0) |-> r_dsg[0])
        else $error("zero divisor without singular flag");

    // An accepted beat enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r1_v)
        else $error("accepted beat dropped at entry");

    // A held pipe keeps the stage valid bits.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_ov == $past(r_ov) && r7_v == $past(r7_v) && r5_v == $past(r5_v)))
        else $error("stage state changed during stall");

endmodule
`default_nettype wire

[bench/mi3_inverse_checker.sv]
`timescale 1ns / 100ps
module mi3_inverse_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mi3_in_if          i_in,
    mi3_out_if         o_out,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_singular_seen,
    output int         o_saturated_seen
);
    import mi3_pkg::*;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
        logic                        singular;
        logic                        saturated;
    } t_inverse;

    t_inverse inverse_q[$];

    // Exact quotient of magnitudes, rounded half away from zero.
    function automatic logic [127:0] div_round(input logic [127:0] num,
                                               input logic [127:0] den);
        logic [127:0] q;
        logic [127:0] rem;
        q   = num / den;
        rem = num % den;
        if ((rem << 1) >= den) q = q + 1;
        return q;
    endfunction

    function automatic t_inverse predict_inverse(input logic signed [23:0] e [0:8]);
        logic signed [63:0]  m [0:8];
        logic signed [63:0]  adj [0:8];
        logic signed [127:0] det;
        logic [127:0]        dmag, amag, q;
        logic [31:0]         res [0:8];
        logic                neg, dneg, sat;
        t_inverse            r;
        for (int i = 0; i < 9; i++) m[i] = e[i];
        // Cofactors in row-major order of the adjugate.
        adj[0] = m[4]*m[8] - m[5]*m[7];
        adj[1] = m[2]*m[7] - m[1]*m[8];
        adj[2] = m[1]*m[5] - m[2]*m[4];
        adj[3] = m[5]*m[6] - m[3]*m[8];
        adj[4] = m[0]*m[8] - m[2]*m[6];
        adj[5] = m[2]*m[3] - m[0]*m[5];
        adj[6] = m[3]*m[7] - m[4]*m[6];
        adj[7] = m[1]*m[6] - m[0]*m[7];
        adj[8] = m[0]*m[4] - m[1]*m[3];
        det = 128'(m[0]) * 128'(adj[0]) + 128'(m[1]) * 128'(adj[3])
            + 128'(m[2]) * 128'(adj[6]);
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        dneg = det < 0;
        dmag = dneg ? -det : det;
        sat  = 1'b0;
        for (int i = 0; i < 9; i++) begin
            amag = adj[i] < 0 ? 128'(-adj[i]) : 128'(adj[i]);
            neg  = (adj[i] < 0) != dneg;
            q    = div_round(amag << 32, dmag);
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    res[i] = 32'h8000_0000;
                    sat = 1'b1;
                end else begin
                    res[i] = -q[31:0];
                end
            end else begin
                if (q > 128'h7FFF_FFFF) begin
                    res[i] = 32'h7FFF_FFFF;
                    sat = 1'b1;
                end else begin
                    res[i] = q[31:0];
                end
            end
        end
        r.b00 = res[0]; r.b01 = res[1]; r.b02 = res[2];
        r.b10 = res[3]; r.b11 = res[4]; r.b12 = res[5];
        r.b20 = res[6]; r.b21 = res[7]; r.b22 = res[8];
        r.saturated = sat;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    assign o_pending = inverse_q.size();

    initial begin
        o_fail_count = 0;
        o_singular_seen = 0;
        o_saturated_seen = 0;
    end

    always @(posedge i_clk) begin
        logic signed [23:0] e [0:8];
        t_inverse exp_r;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                e = '{i_in.a00, i_in.a01, i_in.a02, i_in.a10, i_in.a11, i_in.a12,
                      i_in.a20, i_in.a21, i_in.a22};
                inverse_q = {inverse_q, predict_inverse(e)};
            end
            if (o_out.valid && o_out.ready) begin
                if (inverse_q.size() == 0) begin
                    $error("output beat with no matrix outstanding");
                    o_fail_count++;
                end else begin
                    exp_r = inverse_q.pop_front();
                    check_field("b00", exp_r.b00, o_out.b00);
                    check_field("b01", exp_r.b01, o_out.b01);
                    check_field("b02", exp_r.b02, o_out.b02);
                    check_field("b10", exp_r.b10, o_out.b10);
                    check_field("b11", exp_r.b11, o_out.b11);
                    check_field("b12", exp_r.b12, o_out.b12);
                    check_field("b20", exp_r.b20, o_out.b20);
                    check_field("b21", exp_r.b21, o_out.b21);
                    check_field("b22", exp_r.b22, o_out.b22);
                    check_field("singular", exp_r.singular, o_out.singular);
                    check_field("saturated", exp_r.saturated, o_out.saturated);
                    if (exp_r.singular) o_singular_seen++;
                    if (exp_r.saturated) o_saturated_seen++;
                end
            end
        end
    end
endmodule

[bench/tb_matrix_inverse_3x3_top.sv]
`timescale 1ns / 100ps
module tb_matrix_inverse_3x3_top;
    import mi3_pkg::*;

    localparam int LATENCY     = QUOT_BITS + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   fail_count, pending, singular_seen, saturated_seen;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   hold_cycles = 0;
    int   beats_sent = 0;

    mi3_in_if  in_ch ();
    mi3_out_if out_ch ();

    matrix_inverse_3x3_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    mi3_inverse_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (in_ch),
        .o_out            (out_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_singular_seen  (singular_seen),
        .o_saturated_seen (saturated_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: a forced hold-off takes priority over the random stall rate.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        out_ch.ready = 1'b0;
        {in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
         in_ch.a20, in_ch.a21, in_ch.a22} = '0;
    end

    // Valid stays high between beats sent back to back; idle cycles drop it.
    task automatic send_matrix(input logic [23:0] e [0:8]);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.a00, in_ch.a01, in_ch.a02} <= {e[0], e[1], e[2]};
        {in_ch.a10, in_ch.a11, in_ch.a12} <= {e[3], e[4], e[5]};
        {in_ch.a20, in_ch.a21, in_ch.a22} <= {e[6], e[7], e[8]};
        do @(posedge i_clk); while (!in_ch.ready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [23:0] rand_elem();
        case ($urandom_range(5))
            0: return 24'(signed'($urandom_range(131072)) - 65536);
            1: return 24'h800000 | 24'($urandom_range(1) ? 24'h7FFFFF : 0);
            2: return 24'($urandom_range(3) - 1) << 16;
            3: return 24'(signed'($urandom_range(512)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random;
        logic [23:0] e [0:8];
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++) e[i] = rand_elem();
        // Make some matrices singular by copying or negating a row or column.
        if (kind == 0) begin
            e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
        end else if (kind == 1) begin
            e[1] = -e[0]; e[4] = -e[3]; e[7] = -e[6];
        end
        send_matrix(e);
    endtask

    initial begin
        logic [23:0] e [0:8];
        logic [23:0] one, mx, mn;
        one = 24'h010000;
        mx  = 24'h7FFFFF;
        mn  = 24'h800000;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Identity, scaled identities, extremes, zero, tiny and huge determinants.
        e = '{one, 0, 0, 0, one, 0, 0, 0, one};              send_matrix(e);
        e = '{-one, 0, 0, 0, one<<1, 0, 0, 0, one>>1};       send_matrix(e);
        e = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};                 send_matrix(e);
        e = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};                 send_matrix(e);
        e = '{mx, mn, mx, mn, mx, mn, mx, mn, mn};           send_matrix(e);
        e = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};           send_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                    send_matrix(e);
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                    send_matrix(e);
        e = '{24'hFFFFFF, 0, 0, 0, 1, 0, 0, 0, 1};           send_matrix(e);
        e = '{one, one, one, one, one, one, one, one, one};  send_matrix(e);
        e = '{0, one, 0, 0, 0, one, one, 0, 0};              send_matrix(e);
        e = '{2, 1, 0, 1, 2, 1, 0, 1, 2};                    send_matrix(e);
        e = '{3, 0, 0, 0, 3, 0, 0, 0, 3};                    send_matrix(e);
        e = '{mx, mx, 0, mx, mn, 0, 0, 0, 1};                send_matrix(e);
        e = '{one, 2, 3, 4, 5, 6, 7, 8, 10};                 send_matrix(e);
        e = '{24'h555555, 24'hAAAAAA, 1, 2, 24'h555555, 24'hAAAAAA,
              24'hAAAAAA, 3, 24'h555555};                    send_matrix(e);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = (phase == 1 || phase == 3) ? (phase == 3 ? 29 : 58) : 0;
            receiver_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 29 : 58) : 0;
            if (phase == 0) hold_cycles = 3 * LATENCY;
            for (int n = 0; n < N_RANDOM / 4; n++) send_random();
            // Pause the sender until every outstanding inverse has come back.
            drain();
        end

        repeat (LATENCY + 5) @(posedge i_clk);
        $display("Sent %0d matrices over four idle/stall phases plus a long output hold.",
                 beats_sent);
        $display("Singular results: %0d, saturated results: %0d.",
                 singular_seen, saturated_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
